// ===== sv/sdr_pkg.sv =====
package sdr_pkg;

   // Fixed widths of the word fields.
   localparam int COEF_W      = 32;
   localparam int DISP_W      = 16;
   localparam int DISP_AW     = 19;
   localparam int DISP_DEPTH  = 524288;
   localparam int UPOS_W      = 18;
   localparam int VPOS_W      = 17;
   localparam int REQ_TDATA_W = 112;
   localparam int RSP_TDATA_W = 112;

   // Internal datapath widths.
   localparam int PIX_W   = 19;
   localparam int ADDR_W  = 31;
   localparam int ACC_W   = 60;
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 34;
   localparam int PROD_W  = 67;
   localparam int SUM_W   = 67;

   // Parameter defaults.
   localparam int IMAGE_WIDTH_DEF     = 1024;
   localparam int IMAGE_HEIGHT_DEF    = 512;
   localparam int COORD_FRAC_BITS_DEF = 8;

   typedef enum logic [1:0] {
      OP_WR_DISP = 2'd0,
      OP_WR_COEF = 2'd1,
      OP_NEAREST = 2'd2,
      OP_INTERP  = 2'd3
   } sdr_op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_PREP, S_ADDR_MUL, S_ADDR_ACC, S_WGT_MUL, S_WGT_ACC,
      S_RD, S_RDW, S_DECIDE, S_RP_MUL, S_RP_ACC, S_RP_CHK,
      S_DIV_GO, S_DIV_WAIT, S_RP_END, S_BL_MUL, S_BL_ACC, S_BL_RND, S_FIN
   } sdr_state_type;

   typedef enum logic [1:0] {
      D_IDLE, D_CHECK, D_ITER, D_FIN
   } sdr_div_state_type;

   typedef struct packed {
      logic                    start;
      logic signed [ACC_W-1:0] num;
      logic signed [ACC_W-1:0] den;
   } sdr_div_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [COEF_W-1:0] quot;
   } sdr_div_rsp_type;

endpackage

// ===== sv/sdr_disp_mem.sv =====
module sdr_disp_mem (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [sdr_pkg::DISP_AW-1:0]  wr_addr,
   input  logic [sdr_pkg::DISP_W-1:0]   wr_data,
   input  logic [sdr_pkg::DISP_AW-1:0]  rd_addr,
   output logic [sdr_pkg::DISP_W-1:0]   rd_data
);

   logic [sdr_pkg::DISP_W-1:0] mem [sdr_pkg::DISP_DEPTH];
   logic [sdr_pkg::DISP_W-1:0] rd_data_ff;

   // Single write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sdr_divider.sv =====
module sdr_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  sdr_pkg::sdr_div_req_type div_req,
   output sdr_pkg::sdr_div_rsp_type div_rsp
);

   localparam int AW = sdr_pkg::ACC_W;

   sdr_pkg::sdr_div_state_type dstate_ff, dstate_in;
   logic          neg_ff, neg_in;
   logic          sat_ff, sat_in;
   logic [AW-1:0] n_ff, n_in;
   logic [AW-1:0] d_ff, d_in;
   logic [AW-1:0] rem_ff, rem_in;
   logic [31:0]   q_ff, q_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [31:0]   quot_ff, quot_in;

   logic [AW:0]   rs;
   logic          nbit;
   logic [32:0]   mag;

   // One quotient bit per cycle, restoring, with a saturation check up front.
   always_comb begin
      dstate_in = dstate_ff;
      neg_in    = neg_ff;
      sat_in    = sat_ff;
      n_in      = n_ff;
      d_in      = d_ff;
      rem_in    = rem_ff;
      q_in      = q_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      quot_in   = quot_ff;
      nbit      = cnt_ff[4] ? n_ff[cnt_ff[3:0]] : 1'b0;
      rs        = {rem_ff, nbit};
      mag       = '0;
      unique case (dstate_ff)
         sdr_pkg::D_IDLE: begin
            if (div_req.start) begin
               neg_in    = div_req.num[AW-1] != div_req.den[AW-1];
               n_in      = div_req.num[AW-1] ? AW'(-div_req.num) : AW'(div_req.num);
               d_in      = div_req.den[AW-1] ? AW'(-div_req.den) : AW'(div_req.den);
               q_in      = '0;
               dstate_in = sdr_pkg::D_CHECK;
            end
         end
         sdr_pkg::D_CHECK: begin
            // An integer quotient of 2^16 or more saturates at once.
            if ({16'b0, n_ff} >= {d_ff, 16'b0}) begin
               sat_in    = 1'b1;
               dstate_in = sdr_pkg::D_FIN;
            end else begin
               sat_in    = 1'b0;
               rem_in    = {16'b0, n_ff[AW-1:16]};
               cnt_in    = 5'd31;
               dstate_in = sdr_pkg::D_ITER;
            end
         end
         sdr_pkg::D_ITER: begin
            if (rs >= {1'b0, d_ff}) begin
               rem_in       = AW'(rs - {1'b0, d_ff});
               q_in[cnt_ff] = 1'b1;
            end else begin
               rem_in = rs[AW-1:0];
            end
            if (cnt_ff == 5'd0) begin
               dstate_in = sdr_pkg::D_FIN;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         sdr_pkg::D_FIN: begin
            // Round half away from zero, then saturate to the signed range.
            if (sat_ff) begin
               mag = 33'h1_0000_0000;
            end else begin
               mag = {1'b0, q_ff} + 33'({rem_ff, 1'b0} >= {1'b0, d_ff});
            end
            if (neg_ff) begin
               if (mag > 33'h0_8000_0000) begin
                  mag = 33'h0_8000_0000;
               end
               quot_in = 32'(-mag);
            end else begin
               if (mag > 33'h0_7FFF_FFFF) begin
                  mag = 33'h0_7FFF_FFFF;
               end
               quot_in = mag[31:0];
            end
            done_in   = 1'b1;
            dstate_in = sdr_pkg::D_IDLE;
         end
         default: dstate_in = sdr_pkg::D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dstate_ff <= sdr_pkg::D_IDLE;
         done_ff   <= 1'b0;
      end else begin
         dstate_ff <= dstate_in;
         done_ff   <= done_in;
      end
      neg_ff  <= neg_in;
      sat_ff  <= sat_in;
      n_ff    <= n_in;
      d_ff    <= d_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = $signed(quot_ff);

endmodule

// ===== sv/stereo_disparity_reprojection.sv =====
// Reprojects image points to 3-D using a stored disparity image and a 4x4
// Q16.16 reprojection matrix. Input words with tuser 0 write one disparity
// pixel and tuser 1 write one matrix coefficient; both return nothing.
// Tuser 2 (nearest) and 3 (interpolated) are queries that return one word
// each, with the depth-valid flag in rsp_tuser. Queries run on one shared
// 33x34 multiplier and one bit-serial divider under a sequencer, and the
// block takes no word while a query runs. A reprojection is a 4x4
// matrix-vector multiply-accumulate and three divisions; a nearest query
// and an interpolated query with a missing neighbour each do one
// reprojection, and a fully blended query does four reprojections plus
// twelve blend multiplies. Failing queries return early. A finished result
// waits in the output register while the next word is taken.
module stereo_disparity_reprojection #(
   parameter int IMAGE_WIDTH     = sdr_pkg::IMAGE_WIDTH_DEF,
   parameter int IMAGE_HEIGHT    = sdr_pkg::IMAGE_HEIGHT_DEF,
   parameter int COORD_FRAC_BITS = sdr_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Low to high: pixel_index[18:0], disparity_value[34:19], coef_index[38:35],
   // coef_value[70:39], u_pos[88:71], v_pos[105:89], zeros[111:106].
   input  logic [sdr_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // op[1:0].
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // Low to high: x_pos[31:0], y_pos[63:32], z_pos[95:64],
   // disparity_out[111:96].
   output logic [sdr_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // depth_valid[0].
   output logic                              rsp_tuser
);

   localparam int F      = COORD_FRAC_BITS;
   localparam int WW     = 2 * F + 1;
   localparam int AW     = sdr_pkg::ACC_W;
   localparam int ADW    = sdr_pkg::ADDR_W;
   localparam int SW     = sdr_pkg::SUM_W;
   localparam logic [31:0]    NUM_PIXELS = 32'(IMAGE_WIDTH * IMAGE_HEIGHT);
   localparam logic [17:0]    W_LIM      = 18'(IMAGE_WIDTH);
   localparam logic [17:0]    H_LIM      = 18'(IMAGE_HEIGHT);
   localparam logic [17:0]    W_LIM1     = 18'(IMAGE_WIDTH - 1);
   localparam logic [17:0]    H_LIM1     = 18'(IMAGE_HEIGHT - 1);
   localparam logic [F:0]     ONE        = {1'b1, {F{1'b0}}};
   localparam logic [18:0]    HALF       = 19'(1 << (F - 1));
   localparam logic [SW-1:0]  RND        = SW'(1) << (2 * F - 1);

   // Input word fields.
   logic [18:0] f_pixel;
   logic [15:0] f_disp;
   logic [3:0]  f_cidx;
   logic [31:0] f_coef;
   logic [17:0] f_up;
   logic [16:0] f_vp;
   sdr_pkg::sdr_op_type f_op;
   logic        req_acc;

   assign f_pixel = req_tdata[18:0];
   assign f_disp  = req_tdata[34:19];
   assign f_cidx  = req_tdata[38:35];
   assign f_coef  = req_tdata[70:39];
   assign f_up    = req_tdata[88:71];
   assign f_vp    = req_tdata[105:89];
   assign f_op    = sdr_pkg::sdr_op_type'(req_tuser);

   sdr_pkg::sdr_state_type state_ff, state_in;
   sdr_pkg::sdr_op_type    op_ff, op_in;
   logic [17:0]            up_ff, up_in;
   logic [16:0]            vp_ff, vp_in;
   logic [17:0]            u_ff, u_in;
   logic [17:0]            v_ff, v_in;
   logic [F-1:0]           fu_ff, fu_in;
   logic [F-1:0]           fv_ff, fv_in;
   logic [ADW-1:0]         base_ff, base_in;
   logic [WW-1:0]          w_ff [4];
   logic [WW-1:0]          w_in [4];
   logic [15:0]            d_ff [4];
   logic [15:0]            d_in [4];
   logic                   oob_ff, oob_in;
   logic [1:0]             nb_ff, nb_in;
   logic [1:0]             row_ff, row_in;
   logic [1:0]             col_ff, col_in;
   logic [1:0]             k_ff, k_in;
   logic signed [AW-1:0]   rows_ff [4];
   logic signed [AW-1:0]   rows_in [4];
   logic signed [31:0]     pt_ff [3];
   logic signed [31:0]     pt_in [3];
   logic signed [SW-1:0]   sum_ff [3];
   logic signed [SW-1:0]   sum_in [3];
   logic signed [31:0]     fin_ff [3];
   logic signed [31:0]     fin_in [3];
   logic                   ok_ff, ok_in;
   logic                   blend_ff, blend_in;
   logic [15:0]            dout_ff, dout_in;
   logic signed [sdr_pkg::PROD_W-1:0] prod_ff;
   logic signed [31:0]     matrix_ff [16];
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [sdr_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                   rsp_user_ff, rsp_user_in;

   logic signed [sdr_pkg::MUL_A_W-1:0] mul_a;
   logic signed [sdr_pkg::MUL_B_W-1:0] mul_b;
   logic [F:0]             fac_a, fac_b;
   logic [18:0]            pu, pv;
   logic [18:0]            usum;
   logic [17:0]            vsum;
   logic [ADW-1:0]         rd_full;
   logic [15:0]            rd_data;
   logic                   mem_wr;
   logic signed [31:0]     coef_sel;
   logic [2:0]             missing;
   logic [1:0]             best;
   logic                   found;
   logic [SW-1:0]          mag;
   logic [SW-1:0]          mag_r;
   sdr_pkg::sdr_div_req_type div_req;
   sdr_pkg::sdr_div_rsp_type div_rsp;

   assign req_tready = state_ff == sdr_pkg::S_IDLE;
   assign req_acc    = req_tvalid && req_tready;
   assign mem_wr     = req_acc && f_op == sdr_pkg::OP_WR_DISP
                       && {13'b0, f_pixel} < NUM_PIXELS;

   // Pixel of the neighbour in work and its memory address.
   assign pu       = {1'b0, u_ff} + 19'(nb_ff[0]);
   assign pv       = {1'b0, v_ff} + 19'(nb_ff[1]);
   assign rd_full  = base_ff + (nb_ff[1] ? ADW'(IMAGE_WIDTH) : '0) + ADW'(nb_ff[0]);
   assign coef_sel = matrix_ff[{row_ff, col_ff}];
   assign fac_a    = nb_ff[0] ? {1'b0, fu_ff} : ONE - {1'b0, fu_ff};
   assign fac_b    = nb_ff[1] ? {1'b0, fv_ff} : ONE - {1'b0, fv_ff};
   assign usum     = {1'b0, up_ff} + HALF;
   assign vsum     = {1'b0, vp_ff} + HALF[17:0];

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         sdr_pkg::S_ADDR_MUL: begin
            mul_a = $signed({15'b0, v_ff});
            mul_b = $signed(sdr_pkg::MUL_B_W'(IMAGE_WIDTH));
         end
         sdr_pkg::S_WGT_MUL: begin
            mul_a = $signed(sdr_pkg::MUL_A_W'(fac_a));
            mul_b = $signed(sdr_pkg::MUL_B_W'(fac_b));
         end
         sdr_pkg::S_RP_MUL: begin
            mul_a = {coef_sel[31], coef_sel};
            case (col_ff)
               2'd0:    mul_b = $signed({7'b0, pu, 8'b0});
               2'd1:    mul_b = $signed({7'b0, pv, 8'b0});
               2'd2:    mul_b = $signed({18'b0, d_ff[nb_ff]});
               default: mul_b = $signed(sdr_pkg::MUL_B_W'(256));
            endcase
         end
         sdr_pkg::S_BL_MUL: begin
            mul_a = {pt_ff[k_ff][31], pt_ff[k_ff]};
            mul_b = $signed(sdr_pkg::MUL_B_W'(w_ff[nb_ff]));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Neighbour bookkeeping for the interpolated case.
   always_comb begin
      missing = '0;
      best    = '0;
      found   = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (d_ff[i] == 16'd0) begin
            missing = missing + 3'd1;
         end else if (!found || w_ff[i] > w_ff[best]) begin
            best  = 2'(i);
            found = 1'b1;
         end
      end
   end

   // Sequencer: next state and datapath register updates.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      up_in        = up_ff;
      vp_in        = vp_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      fu_in        = fu_ff;
      fv_in        = fv_ff;
      base_in      = base_ff;
      w_in         = w_ff;
      d_in         = d_ff;
      oob_in       = oob_ff;
      nb_in        = nb_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      k_in         = k_ff;
      rows_in      = rows_ff;
      pt_in        = pt_ff;
      sum_in       = sum_ff;
      fin_in       = fin_ff;
      ok_in        = ok_ff;
      blend_in     = blend_ff;
      dout_in      = dout_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      div_req      = '0;
      mag          = '0;
      mag_r        = '0;
      unique case (state_ff)
         sdr_pkg::S_IDLE: begin
            if (req_acc && (f_op == sdr_pkg::OP_NEAREST || f_op == sdr_pkg::OP_INTERP)) begin
               op_in    = f_op;
               up_in    = f_up;
               vp_in    = f_vp;
               state_in = sdr_pkg::S_PREP;
            end
         end
         sdr_pkg::S_PREP: begin
            // Round or truncate the point and check it against the image.
            dout_in = '0;
            ok_in   = 1'b0;
            nb_in   = '0;
            fu_in   = up_ff[F-1:0];
            fv_in   = vp_ff[F-1:0];
            if (op_ff == sdr_pkg::OP_NEAREST) begin
               u_in = 18'(usum >> F);
               v_in = 18'(vsum >> F);
               if (18'(usum >> F) >= W_LIM || 18'(vsum >> F) >= H_LIM) begin
                  state_in = sdr_pkg::S_FIN;
               end else begin
                  state_in = sdr_pkg::S_ADDR_MUL;
               end
            end else begin
               u_in = 18'(up_ff >> F);
               v_in = 18'(vp_ff >> F);
               if (18'(up_ff >> F) >= W_LIM1 || 18'(vp_ff >> F) >= H_LIM1) begin
                  state_in = sdr_pkg::S_FIN;
               end else begin
                  state_in = sdr_pkg::S_ADDR_MUL;
               end
            end
         end
         sdr_pkg::S_ADDR_MUL: begin
            state_in = sdr_pkg::S_ADDR_ACC;
         end
         sdr_pkg::S_ADDR_ACC: begin
            base_in  = prod_ff[ADW-1:0] + ADW'(u_ff);
            state_in = (op_ff == sdr_pkg::OP_INTERP) ? sdr_pkg::S_WGT_MUL : sdr_pkg::S_RD;
         end
         sdr_pkg::S_WGT_MUL: begin
            state_in = sdr_pkg::S_WGT_ACC;
         end
         sdr_pkg::S_WGT_ACC: begin
            w_in[nb_ff] = prod_ff[WW-1:0];
            if (nb_ff == 2'd3) begin
               nb_in    = '0;
               state_in = sdr_pkg::S_RD;
            end else begin
               nb_in    = nb_ff + 2'd1;
               state_in = sdr_pkg::S_WGT_MUL;
            end
         end
         sdr_pkg::S_RD: begin
            oob_in   = rd_full >= ADW'(sdr_pkg::DISP_DEPTH);
            state_in = sdr_pkg::S_RDW;
         end
         sdr_pkg::S_RDW: begin
            d_in[nb_ff] = oob_ff ? 16'd0 : rd_data;
            if (op_ff == sdr_pkg::OP_NEAREST) begin
               dout_in  = oob_ff ? 16'd0 : rd_data;
               state_in = sdr_pkg::S_DECIDE;
            end else if (nb_ff == 2'd3) begin
               state_in = sdr_pkg::S_DECIDE;
            end else begin
               nb_in    = nb_ff + 2'd1;
               state_in = sdr_pkg::S_RD;
            end
         end
         sdr_pkg::S_DECIDE: begin
            row_in = '0;
            col_in = '0;
            if (op_ff == sdr_pkg::OP_NEAREST) begin
               nb_in    = '0;
               blend_in = 1'b0;
               state_in = (d_ff[0] == 16'd0) ? sdr_pkg::S_FIN : sdr_pkg::S_RP_MUL;
            end else if (missing == 3'd4) begin
               state_in = sdr_pkg::S_FIN;
            end else if (missing != 3'd0) begin
               nb_in    = best;
               blend_in = 1'b0;
               state_in = sdr_pkg::S_RP_MUL;
            end else begin
               nb_in    = '0;
               blend_in = 1'b1;
               state_in = sdr_pkg::S_RP_MUL;
            end
         end
         sdr_pkg::S_RP_MUL: begin
            state_in = sdr_pkg::S_RP_ACC;
         end
         sdr_pkg::S_RP_ACC: begin
            // One term of a row sum of the matrix-vector product.
            if (col_ff == 2'd0) begin
               rows_in[row_ff] = $signed(prod_ff[AW-1:0]);
            end else begin
               rows_in[row_ff] = rows_ff[row_ff] + $signed(prod_ff[AW-1:0]);
            end
            if (col_ff == 2'd3) begin
               col_in = '0;
               if (row_ff == 2'd3) begin
                  state_in = sdr_pkg::S_RP_CHK;
               end else begin
                  row_in   = row_ff + 2'd1;
                  state_in = sdr_pkg::S_RP_MUL;
               end
            end else begin
               col_in   = col_ff + 2'd1;
               state_in = sdr_pkg::S_RP_MUL;
            end
         end
         sdr_pkg::S_RP_CHK: begin
            k_in     = '0;
            state_in = (rows_ff[3] == '0) ? sdr_pkg::S_FIN : sdr_pkg::S_DIV_GO;
         end
         sdr_pkg::S_DIV_GO: begin
            div_req.start = 1'b1;
            div_req.num   = rows_ff[k_ff];
            div_req.den   = rows_ff[3];
            state_in      = sdr_pkg::S_DIV_WAIT;
         end
         sdr_pkg::S_DIV_WAIT: begin
            if (div_rsp.done) begin
               pt_in[k_ff] = div_rsp.quot;
               if (k_ff == 2'd2) begin
                  state_in = sdr_pkg::S_RP_END;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = sdr_pkg::S_DIV_GO;
               end
            end
         end
         sdr_pkg::S_RP_END: begin
            k_in = '0;
            if (blend_ff) begin
               state_in = sdr_pkg::S_BL_MUL;
            end else begin
               fin_in   = pt_ff;
               ok_in    = 1'b1;
               state_in = sdr_pkg::S_FIN;
            end
         end
         sdr_pkg::S_BL_MUL: begin
            state_in = sdr_pkg::S_BL_ACC;
         end
         sdr_pkg::S_BL_ACC: begin
            // Weighted sum of the four reprojected points.
            sum_in[k_ff] = ((nb_ff == 2'd0) ? SW'(0) : sum_ff[k_ff]) + SW'(prod_ff);
            if (k_ff == 2'd2) begin
               k_in = '0;
               if (nb_ff == 2'd3) begin
                  state_in = sdr_pkg::S_BL_RND;
               end else begin
                  nb_in    = nb_ff + 2'd1;
                  row_in   = '0;
                  col_in   = '0;
                  state_in = sdr_pkg::S_RP_MUL;
               end
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = sdr_pkg::S_BL_MUL;
            end
         end
         sdr_pkg::S_BL_RND: begin
            // Divide by the total weight, rounding half away from zero.
            for (int k = 0; k < 3; k++) begin
               mag   = sum_ff[k][SW-1] ? SW'(-sum_ff[k]) : SW'(sum_ff[k]);
               mag_r = (mag + RND) >> (2 * F);
               fin_in[k] = sum_ff[k][SW-1] ? $signed(32'(-mag_r)) : $signed(mag_r[31:0]);
            end
            ok_in    = 1'b1;
            state_in = sdr_pkg::S_FIN;
         end
         sdr_pkg::S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = ok_ff;
               rsp_data_in  = {dout_ff,
                               ok_ff ? fin_ff[2] : 32'sd0,
                               ok_ff ? fin_ff[1] : 32'sd0,
                               ok_ff ? fin_ff[0] : 32'sd0};
               state_in     = sdr_pkg::S_IDLE;
            end
         end
         default: state_in = sdr_pkg::S_IDLE;
      endcase
   end

   // Control and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdr_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      up_ff       <= up_in;
      vp_ff       <= vp_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      fu_ff       <= fu_in;
      fv_ff       <= fv_in;
      base_ff     <= base_in;
      w_ff        <= w_in;
      d_ff        <= d_in;
      oob_ff      <= oob_in;
      nb_ff       <= nb_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      k_ff        <= k_in;
      rows_ff     <= rows_in;
      pt_ff       <= pt_in;
      sum_ff      <= sum_in;
      fin_ff      <= fin_in;
      ok_ff       <= ok_in;
      blend_ff    <= blend_in;
      dout_ff     <= dout_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      prod_ff     <= mul_a * mul_b;
   end

   // Matrix coefficient store.
   always_ff @(posedge clock) begin
      if (req_acc && f_op == sdr_pkg::OP_WR_COEF) begin
         matrix_ff[f_cidx] <= $signed(f_coef);
      end
   end

   sdr_disp_mem u_disp_mem (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (f_pixel),
      .wr_data (f_disp),
      .rd_addr (rd_full[sdr_pkg::DISP_AW-1:0]),
      .rd_data (rd_data)
   );

   sdr_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
